FILE: hw/rtl/s2m_pkg.sv
// Shared types and constants for the stick-to-mouse motion block.
// Depends on nothing; every other file of the block imports it.
package s2m_pkg;

  localparam int SMP_W      = 16;  // raw stick sample
  localparam int DZ_W       = 15;  // deadzone radius
  localparam int MAG_W      = 16;  // deadzone output magnitude
  localparam int MSQ_W      = 32;  // squared radius
  localparam int ROOT_W     = 16;  // floor square root
  localparam int DEN_W      = 31;  // m * (32768 - dz)
  localparam int PNUM_W     = 32;  // |a| * (m - dz)
  localparam int NUM_SHIFT  = 15;  // times 32768
  localparam int NUM_W      = PNUM_W + NUM_SHIFT;
  localparam int QUO_W      = 16;  // deadzone quotient, saturating
  localparam int ALPHA_W    = 9;
  localparam int Q8_SHIFT   = 8;
  localparam int GAIN_W     = 16;
  localparam int SGAIN_W    = 24;
  localparam int A16_W      = 26;
  localparam int MB_W       = 26;  // widest serial multiplier operand
  localparam int MOVE_W     = 7;
  localparam int WHEEL_W    = 8;
  localparam int MOVE_LIM   = 32;
  localparam int WHEEL_POS  = 127;
  localparam int WHEEL_NEG  = 128;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ALPHA_W-1:0] ONE_Q8     = 9'd256;
  localparam logic [MAG_W-1:0]   FULL_SCALE = 16'h8000;
  localparam logic [A16_W-1:0]   ONE_Q16    = 26'd65536;

  localparam logic [DZ_W-1:0]    RST_CURSOR_DZ  = 15'd4000;
  localparam logic [DZ_W-1:0]    RST_SCROLL_DZ  = 15'd8000;
  localparam logic [ALPHA_W-1:0] RST_ALPHA      = 9'd179;
  localparam logic [15:0]        RST_PREC_THR   = 16'd19661;
  localparam logic [GAIN_W-1:0]  RST_CURSOR_GN  = 16'd1638;
  localparam logic [15:0]        RST_ACCEL      = 16'd384;
  localparam logic [ALPHA_W-1:0] RST_PREC_SCALE = 9'd102;
  localparam logic [SGAIN_W-1:0] RST_SCROLL_GN  = 24'd40265;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURSOR_DZ, CFG_SCROLL_DZ, CFG_ALPHA, CFG_PREC_THR,
    CFG_CURSOR_GAIN, CFG_ACCEL, CFG_PREC_SCALE, CFG_SCROLL_GAIN
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_DZSQ, ST_ROOT, ST_DEN, ST_NUM, ST_QUO,
    ST_FNEW, ST_FOLD, ST_FSUM, ST_VNG, ST_VAN, ST_VFIN, ST_ACC, ST_DONE
  } st_t;

  function automatic logic [SMP_W-1:0] mag16(input logic [SMP_W-1:0] v);
    return v[SMP_W-1] ? (~v + 16'd1) : v;
  endfunction

endpackage

FILE: hw/rtl/s2m_mul.sv
// Shift-add multiplier, one bit of the second operand per cycle.
// Depends on s2m_pkg; operand widths are set by the instantiating module.
module s2m_mul #(
  parameter int WA = 33,
  parameter int WB = 26
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic            done,
  output logic [WA+WB-1:0] prod
);
  import s2m_pkg::*;

  localparam int PW = WA + WB;

  logic          busy;
  logic [PW-1:0] a_sh;
  logic [WB-1:0] b_sh;

  assign done = busy && (b_sh == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // advance one multiplier bit per cycle; stop once no set bits remain
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      a_sh <= PW'(a);
      b_sh <= b;
    end else if (busy && b_sh != '0) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

FILE: hw/rtl/s2m_div.sv
// Restoring divider for the deadzone rescale, one quotient bit per cycle.
// Depends on s2m_pkg for the operand widths; saturates to all ones.
module s2m_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [s2m_pkg::NUM_W-1:0] num,
  input  logic [s2m_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [s2m_pkg::QUO_W-1:0] quo
);
  import s2m_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] nsh;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic             ovf;

  assign trial = {rem, nsh[QUO_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign ovf   = num >= {den, {QUO_W{1'b0}}};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ovf ? '0 : CW'(QUO_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[NUM_W-1:QUO_W];
      nsh <= num[QUO_W-1:0];
      quo <= ovf ? '1 : '0;
    end else if (busy && cnt != '0) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      nsh <= nsh << 1;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/s2m_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on s2m_pkg for the radicand and root widths.
module s2m_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [s2m_pkg::MSQ_W-1:0]  rad,
  output logic                       done,
  output logic [s2m_pkg::ROOT_W-1:0] root
);
  import s2m_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [MSQ_W-1:0]  rad_sh;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+3:0] t;
  logic [ROOT_W+3:0] trial;
  logic              ge;

  assign t     = {rem, rad_sh[MSQ_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = t >= trial;
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(ROOT_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy && cnt != '0) begin
      rad_sh <= rad_sh << 2;
      rem    <= ge ? (ROOT_W+2)'(t - trial) : (ROOT_W+2)'(t);
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/stick_to_mouse_motion_top.sv
// Stick-to-mouse motion: one request per tick, one result per request.
// Timing: each multiply step uses the shared shift-add multiplier, whose run is set
// by the bit length of its second operand; a divide whose quotient saturates ends
// early. A tick's length is set by operand bit lengths and by whether each stick
// lands in its deadzone.
// Next request: taken in the cycle after the result is loaded, also
// while that result still waits at the output.
// Reset (synchronous): registers to defaults, filters, residues and buttons to zero.
module stick_to_mouse_motion_top #(
  parameter int FILTER_FRAC_BITS  = 8,
  parameter int RESIDUE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [s2m_pkg::SMP_W-1:0]  left_x,
  input  logic signed [s2m_pkg::SMP_W-1:0]  left_y,
  input  logic signed [s2m_pkg::SMP_W-1:0]  right_x,
  input  logic signed [s2m_pkg::SMP_W-1:0]  right_y,
  input  logic                              left_bumper,
  input  logic                              right_bumper,
  input  logic                              stick_click,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [s2m_pkg::MOVE_W-1:0]  move_x,
  output logic signed [s2m_pkg::MOVE_W-1:0]  move_y,
  output logic signed [s2m_pkg::WHEEL_W-1:0] wheel_x,
  output logic signed [s2m_pkg::WHEEL_W-1:0] wheel_y,
  output logic                              left_changed,
  output logic                              left_pressed,
  output logic                              right_changed,
  output logic                              right_pressed,
  output logic                              middle_changed,
  output logic                              middle_pressed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [s2m_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [s2m_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import s2m_pkg::*;

  localparam int FB      = FILTER_FRAC_BITS;
  localparam int RB      = RESIDUE_FRAC_BITS;
  localparam int FABS_W  = SMP_W + FB;          // |filter|
  localparam int FW      = FABS_W + 1;          // signed filter state
  localparam int N_W     = SMP_W + 1;           // normalised deflection, Q1.16
  localparam int NG_W    = N_W + GAIN_W;        // n * gain
  localparam int MA_W    = (FABS_W > NG_W) ? FABS_W : NG_W;
  localparam int MP_W    = MA_W + MB_W;
  localparam int T1_W    = ALPHA_W + MAG_W;     // alpha * |d|
  localparam int T_W     = T1_W + FB;
  localparam int SUM_W   = T_W + 2;
  localparam int RW      = RB + 1;              // signed residue
  localparam int ACC_W   = MP_W + 2;
  localparam int WH_W    = ACC_W - RB;
  localparam int SH_PREC = 32 - RB;
  localparam int SH_ACC  = 40 - RB;
  localparam int SH_SCR  = FB + 24 - RB;

  // configuration registers
  logic [DZ_W-1:0]    cursor_deadzone;
  logic [DZ_W-1:0]    wheel_deadzone;
  logic [ALPHA_W-1:0] smooth_weight;
  logic [15:0]        fine_limit;
  logic [GAIN_W-1:0]  cursor_gain;
  logic [15:0]        accel_factor;
  logic [ALPHA_W-1:0] fine_scale;
  logic [SGAIN_W-1:0] scroll_gain;

  // sequencer
  st_t  state, state_next;
  logic launched;
  logic stk;   // 0 cursor stick, 1 scroll stick
  logic axis;  // 0 X, 1 Y
  logic [1:0] idx;

  // request hold and long-lived state
  logic signed [SMP_W-1:0] smp [4];
  logic [2:0]              btn;
  logic [2:0]              previous_buttons;
  logic signed [FW-1:0]    filt [4];
  logic signed [RW-1:0]    resid [4];

  // working registers
  logic [MSQ_W-1:0]  msq;
  logic [ROOT_W-1:0] m;
  logic [DEN_W-1:0]  den;
  logic [PNUM_W-1:0] num;
  logic [MAG_W-1:0]  dmag [2];
  logic              dneg [2];
  logic [T1_W-1:0]   t1;
  logic [T_W-1:0]    t2;
  logic [NG_W-1:0]   ng;
  logic [A16_W-1:0]  a16;
  logic [MP_W-1:0]   vmag;
  logic [MOVE_W-1:0]  mv [2];
  logic [WHEEL_W-1:0] wh [2];

  // arithmetic units
  logic              mul_start, mul_done;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_prod;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [QUO_W-1:0]  div_quo;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  // operand views
  logic [DZ_W-1:0]    dz;
  logic [SMP_W-1:0]   ax, ay, asel;
  logic [ALPHA_W-1:0] alpha_eff, ps_eff;
  logic signed [FW-1:0] fcur;
  logic               fneg;
  logic [FABS_W-1:0]  fabs;
  logic [N_W-1:0]     nval;
  logic               in_prec;
  logic               dz_inside;
  logic               fire;
  logic               in_acc;

  // filter update
  logic signed [SUM_W-1:0] s_new, s_old, s_sum;
  logic [SUM_W-1:0]        s_mag;
  logic signed [FW-1:0]    f_upd;

  // residue update
  logic signed [ACC_W-1:0] acc_v, acc_sum;
  logic [ACC_W-1:0]        acc_mag;
  logic [WH_W-1:0]         whole;
  logic                    acc_neg;
  logic signed [RW-1:0]    res_upd;
  logic [MOVE_W-1:0]       mv_upd;
  logic [WHEEL_W-1:0]      wh_upd;

  s2m_mul #(.WA(MA_W), .WB(MB_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  s2m_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  s2m_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (msq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign fire      = (state == ST_DONE) && (!out_valid || out_ready);

  assign idx  = {stk, axis};
  assign dz   = stk ? wheel_deadzone : cursor_deadzone;
  assign ax   = mag16(smp[{stk, 1'b0}]);
  assign ay   = mag16(smp[{stk, 1'b1}]);
  assign asel = axis ? ay : ax;

  // alpha and precision scale saturate at one on use
  assign alpha_eff = (smooth_weight > ONE_Q8) ? ONE_Q8 : smooth_weight;
  assign ps_eff    = (fine_scale > ONE_Q8) ? ONE_Q8 : fine_scale;

  assign fcur    = filt[idx];
  assign fneg    = fcur[FW-1];
  assign fabs    = fneg ? FABS_W'(-fcur) : FABS_W'(fcur);
  assign nval    = N_W'(fabs >> (FB - 1));
  assign in_prec = nval < {1'b0, fine_limit};

  // inside the deadzone when x*x + y*y < dz*dz
  assign dz_inside = msq < MSQ_W'(mul_prod);
  assign div_num   = {num, {NUM_SHIFT{1'b0}}};

  // --------------------------------------------------------------------------
  // Next state. Per stick: deadzone (squares, root, rescale both axes), then
  // per axis: smoothing, cursor velocity curve, residue. Cursor, then scroll.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQX;
      ST_SQX:  if (mul_done) state_next = ST_SQY;
      ST_SQY:  if (mul_done) state_next = ST_DZSQ;
      ST_DZSQ: if (mul_done) state_next = dz_inside ? ST_FNEW : ST_ROOT;
      ST_ROOT: if (sqrt_done) state_next = (sqrt_root == '0) ? ST_FNEW : ST_DEN;
      ST_DEN:  if (mul_done) state_next = ST_NUM;
      ST_NUM:  if (mul_done) state_next = ST_QUO;
      ST_QUO:  if (div_done) state_next = axis ? ST_FNEW : ST_NUM;
      ST_FNEW: if (mul_done) state_next = ST_FOLD;
      ST_FOLD: if (mul_done) state_next = ST_FSUM;
      ST_FSUM: state_next = stk ? ST_VFIN : ST_VNG;
      ST_VNG:  if (mul_done) state_next = ST_VAN;
      ST_VAN:  if (mul_done) state_next = ST_VFIN;
      ST_VFIN: if (mul_done) state_next = ST_ACC;
      ST_ACC: begin
        if (!axis) begin
          state_next = ST_FNEW;
        end else if (!stk) begin
          state_next = ST_SQX;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: if (fire) state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Unit launches and operand selection. Each unit is started once on entry
  // to its step; the step holds until that unit reports done.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_SQX: begin
        mul_a = MA_W'(ax);
        mul_b = MB_W'(ax);
        mul_start = !launched;
      end
      ST_SQY: begin
        mul_a = MA_W'(ay);
        mul_b = MB_W'(ay);
        mul_start = !launched;
      end
      ST_DZSQ: begin
        mul_a = MA_W'(dz);
        mul_b = MB_W'(dz);
        mul_start = !launched;
      end
      ST_DEN: begin
        mul_a = MA_W'(m);
        mul_b = MB_W'(FULL_SCALE - {1'b0, dz});
        mul_start = !launched;
      end
      ST_NUM: begin
        mul_a = MA_W'(asel);
        mul_b = MB_W'(m - {1'b0, dz});
        mul_start = !launched;
      end
      ST_FNEW: begin
        mul_a = MA_W'(dmag[axis]);
        mul_b = MB_W'(alpha_eff);
        mul_start = !launched;
      end
      ST_FOLD: begin
        mul_a = MA_W'(fabs);
        mul_b = MB_W'(ONE_Q8 - alpha_eff);
        mul_start = !launched;
      end
      ST_VNG: begin
        mul_a = MA_W'(nval);
        mul_b = MB_W'(cursor_gain);
        mul_start = !launched;
      end
      ST_VAN: begin
        mul_a = MA_W'(accel_factor);
        mul_b = MB_W'(nval);
        mul_start = !launched;
      end
      ST_VFIN: begin
        if (stk) begin
          mul_a = MA_W'(fabs);
          mul_b = MB_W'(scroll_gain);
        end else begin
          mul_a = MA_W'(ng);
          mul_b = in_prec ? MB_W'(ps_eff) : MB_W'(a16);
        end
        mul_start = !launched;
      end
      ST_ROOT: sqrt_start = !launched;
      ST_QUO:  div_start  = !launched;
      ST_IDLE, ST_FSUM, ST_ACC, ST_DONE: ;
    endcase
  end

  // new filter value: (alpha*(d << F) + (1 - alpha)*f) / 256, toward zero
  always_comb begin
    s_new = SUM_W'({t1, {FB{1'b0}}});
    if (dneg[axis]) begin
      s_new = -s_new;
    end
    s_old = SUM_W'(t2);
    if (fneg) begin
      s_old = -s_old;
    end
    s_sum = s_new + s_old;
    s_mag = s_sum[SUM_W-1] ? SUM_W'(-s_sum) : SUM_W'(s_sum);
    f_upd = FW'(s_mag >> Q8_SHIFT);
    if (s_sum[SUM_W-1]) begin
      f_upd = -f_upd;
    end
  end

  // residue plus velocity; whole part toward zero leaves, fraction stays
  always_comb begin
    acc_v = ACC_W'(vmag);
    if (fneg ^ axis) begin
      acc_v = -acc_v;  // Y is inverted
    end
    acc_sum = acc_v + {{(ACC_W-RW){resid[idx][RW-1]}}, resid[idx]};
    acc_neg = acc_sum[ACC_W-1];
    acc_mag = acc_neg ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
    whole   = acc_mag[ACC_W-1:RB];
    res_upd = RW'({1'b0, acc_mag[RB-1:0]});
    if (acc_neg) begin
      res_upd = -res_upd;
    end
    mv_upd = (whole > WH_W'(MOVE_LIM)) ? MOVE_W'(MOVE_LIM) : MOVE_W'(whole);
    if (acc_neg) begin
      mv_upd = -mv_upd;
      wh_upd = (whole > WH_W'(WHEEL_NEG)) ? WHEEL_W'(WHEEL_NEG) : WHEEL_W'(whole);
      wh_upd = -wh_upd;
    end else begin
      wh_upd = (whole > WH_W'(WHEEL_POS)) ? WHEEL_W'(WHEEL_POS) : WHEEL_W'(whole);
    end
  end

  // control state, configuration and per-tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      launched            <= 1'b0;
      stk                 <= 1'b0;
      axis                <= 1'b0;
      out_valid           <= 1'b0;
      previous_buttons    <= '0;
      cursor_deadzone     <= RST_CURSOR_DZ;
      wheel_deadzone      <= RST_SCROLL_DZ;
      smooth_weight       <= RST_ALPHA;
      fine_limit          <= RST_PREC_THR;
      cursor_gain         <= RST_CURSOR_GN;
      accel_factor        <= RST_ACCEL;
      fine_scale          <= RST_PREC_SCALE;
      scroll_gain         <= RST_SCROLL_GN;
      for (int i = 0; i < 4; i++) begin
        filt[i]  <= '0;
        resid[i] <= '0;
      end
    end else begin
      state    <= state_next;
      launched <= (launched | mul_start | div_start | sqrt_start)
                  & ~(mul_done | div_done | sqrt_done);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CURSOR_DZ:   cursor_deadzone <= cfg_data[DZ_W-1:0];
          CFG_SCROLL_DZ:   wheel_deadzone  <= cfg_data[DZ_W-1:0];
          CFG_ALPHA:       smooth_weight   <= cfg_data[ALPHA_W-1:0];
          CFG_PREC_THR:    fine_limit      <= cfg_data[15:0];
          CFG_CURSOR_GAIN: cursor_gain     <= cfg_data[GAIN_W-1:0];
          CFG_ACCEL:       accel_factor    <= cfg_data[15:0];
          CFG_PREC_SCALE:  fine_scale      <= cfg_data[ALPHA_W-1:0];
          CFG_SCROLL_GAIN: scroll_gain     <= cfg_data[SGAIN_W-1:0];
        endcase
      end

      // axis and stick walk
      if (in_acc) begin
        stk  <= 1'b0;
        axis <= 1'b0;
      end else if ((state == ST_QUO && div_done) || state == ST_ACC) begin
        axis <= ~axis;
        if (state == ST_ACC && axis) begin
          stk <= ~stk;
        end
      end

      if (state == ST_FSUM) begin
        filt[idx] <= f_upd;
      end
      if (state == ST_ACC) begin
        resid[idx] <= res_upd;
      end

      // result register: drop on take, load when the slot is free
      if (fire) begin
        out_valid        <= 1'b1;
        previous_buttons <= btn;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp[0] <= left_x;
      smp[1] <= left_y;
      smp[2] <= right_x;
      smp[3] <= right_y;
      btn    <= {stick_click, right_bumper, left_bumper};
    end

    unique case (state)
      ST_SQX:  if (mul_done) msq <= MSQ_W'(mul_prod);
      ST_SQY:  if (mul_done) msq <= msq + MSQ_W'(mul_prod);
      ST_DZSQ: begin
        if (mul_done && dz_inside) begin
          dmag[0] <= '0;
          dmag[1] <= '0;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          m <= sqrt_root;
          if (sqrt_root == '0) begin
            dmag[0] <= '0;
            dmag[1] <= '0;
          end
        end
      end
      ST_DEN:  if (mul_done) den <= DEN_W'(mul_prod);
      ST_NUM:  if (mul_done) num <= PNUM_W'(mul_prod);
      ST_QUO: begin
        if (div_done) begin
          dmag[axis] <= div_quo;
          dneg[axis] <= smp[idx][SMP_W-1];
        end
      end
      ST_FNEW: if (mul_done) t1 <= T1_W'(mul_prod);
      ST_FOLD: if (mul_done) t2 <= T_W'(mul_prod);
      ST_VNG:  if (mul_done) ng <= NG_W'(mul_prod);
      ST_VAN:  if (mul_done) a16 <= ONE_Q16 + A16_W'(mul_prod >> Q8_SHIFT);
      ST_VFIN: begin
        if (mul_done) begin
          if (stk) begin
            vmag <= mul_prod >> SH_SCR;
          end else if (in_prec) begin
            vmag <= mul_prod >> SH_PREC;
          end else begin
            vmag <= mul_prod >> SH_ACC;
          end
        end
      end
      ST_ACC: begin
        // cursor pass fills the moves, scroll pass the wheel steps
        if (stk) begin
          wh[axis] <= wh_upd;
        end else begin
          mv[axis] <= mv_upd;
        end
      end
      ST_IDLE, ST_FSUM, ST_DONE: ;
    endcase

    if (fire) begin
      move_x         <= mv[0];
      move_y         <= mv[1];
      wheel_x        <= wh[0];
      wheel_y        <= wh[1];
      left_changed   <= btn[0] ^ previous_buttons[0];
      left_pressed   <= btn[0];
      right_changed  <= btn[1] ^ previous_buttons[1];
      right_pressed  <= btn[1];
      middle_changed <= btn[2] ^ previous_buttons[2];
      middle_pressed <= btn[2];
    end
  end

endmodule
